// ===== src/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int AW           = 32;
  localparam int SIZE_REQ_W   = 16;
  localparam int SZW          = 17;
  localparam int TIER_W       = 2;
  localparam int CNT_W        = 11;
  localparam int IDX_OUT_W    = 10;
  localparam int CTR_W        = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int MIN_SIZE     = 8;
  localparam int AUTO_MIN     = 32;

  localparam logic [AW-1:0]         RST_POOL_BASE = AW'(65536);
  localparam logic [SIZE_REQ_W-1:0] RST_SIZE_REQ  = SIZE_REQ_W'(64);
  localparam logic [TIER_W-1:0]     RST_TIER      = '0;
  localparam logic [CNT_W-1:0]      RST_INIT_BLKS = CNT_W'(256);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_GROW  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RS_OK           = 3'd0,
    RS_EXHAUSTED    = 3'd1,
    RS_BAD_ADDRESS  = 3'd2,
    RS_NOT_ALLOC    = 3'd3,
    RS_GROW_REFUSED = 3'd4
  } res_status_t;

  typedef enum logic [2:0] {
    CFG_POOL_BASE  = 3'd0,
    CFG_SIZE_REQ   = 3'd1,
    CFG_TIER       = 3'd2,
    CFG_INIT_BLKS  = 3'd3,
    CFG_ALLOW_GROW = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_GROW,
    S_POP_RD,
    S_POP_MUL,
    S_POP_FIN,
    S_FREE_MUL,
    S_FREE_CHK,
    S_DIV,
    S_BIT_RD,
    S_BIT_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        take;
    logic        sweep_step;
    logic        clear_done;
    logic        grow_start;
    logic        grow_step;
    logic        pop_read;
    logic        pop_mul;
    logic        pop_commit;
    logic        fail_count;
    logic        free_prep;
    logic        div_start;
    logic        div_step;
    logic        bit_read;
    logic        free_commit;
    logic        res_set;
    res_status_t res_code;
    logic        result_load;
  } fbpa_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic stack_empty;
    logic grow_allowed;
    logic grow_fits;
    logic grow_zero;
    logic sweep_last;
    logic grow_last;
    logic div_last;
    logic free_bad;
    logic rem_nonzero;
    logic bit_set;
    logic out_busy;
  } fbpa_sts_t;

  function automatic logic [SZW-1:0] eff_size(logic [SIZE_REQ_W-1:0] req,
                                               logic [TIER_W-1:0] tier);
    logic [SZW-1:0] s;
    logic [SZW-1:0] am;
    s = (req < SIZE_REQ_W'(MIN_SIZE)) ? SZW'(MIN_SIZE) : SZW'(req);
    case (tier)
      2'd0:    am = SZW'(31);
      2'd1:    am = SZW'(15);
      2'd2:    am = SZW'(7);
      default: am = SZW'(3);
    endcase
    return (s + am) & ~am;
  endfunction

endpackage

// ===== src/fbpa_if.sv =====
interface fbpa_in_if import fbpa_pkg::*; ();
  logic             valid;
  logic             ready;
  cmd_t             cmd;
  logic [AW-1:0]    address;
  logic [CNT_W-1:0] grow_count;
  logic             force_grow;

  modport source (output valid, cmd, address, grow_count, force_grow, input ready);
  modport sink   (input valid, cmd, address, grow_count, force_grow, output ready);
endinterface

interface fbpa_out_if import fbpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  res_status_t          status;
  logic [AW-1:0]        block_address;
  logic [IDX_OUT_W-1:0] block_index;
  logic [CNT_W-1:0]     free_blocks;
  logic [CNT_W-1:0]     active_blocks;
  logic [CTR_W-1:0]     total_allocations;
  logic [CTR_W-1:0]     total_releases;
  logic [CTR_W-1:0]     allocation_failures;

  modport source (output valid, ok, status, block_address, block_index, free_blocks,
                  active_blocks, total_allocations, total_releases,
                  allocation_failures, input ready);
  modport sink   (input valid, ok, status, block_address, block_index, free_blocks,
                  active_blocks, total_allocations, total_releases,
                  allocation_failures, output ready);
endinterface

// ===== src/fixed_block_pool_allocator.sv =====
// allocate may first grow the pool automatically; free runs the one-bit-per-cycle restoring
// divider; clear sweeps one stack and allocated-bit entry per cycle
// throughput: one item at a time; the next input transfer is taken once the result is registered
// reset: synchronous active-low; a sweep then fills the stack and clears
// the allocated bits, with no input transfer taken until it ends
module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fbpa_in_if.sink               in_ch,
  fbpa_out_if.source            out_ch
);

  fbpa_ctl_t ctl;
  fbpa_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  fbpa_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_cmd                  (in_ch.cmd),
    .in_address              (in_ch.address),
    .in_grow_count           (in_ch.grow_count),
    .in_force_grow           (in_ch.force_grow),
    .out_ready               (out_ch.ready),
    .out_valid               (out_ch.valid),
    .out_ok                  (out_ch.ok),
    .out_status              (out_ch.status),
    .out_block_address       (out_ch.block_address),
    .out_block_index         (out_ch.block_index),
    .out_free_blocks         (out_ch.free_blocks),
    .out_active_blocks       (out_ch.active_blocks),
    .out_total_allocations   (out_ch.total_allocations),
    .out_total_releases      (out_ch.total_releases),
    .out_allocation_failures (out_ch.allocation_failures),
    .ctl                     (ctl),
    .sts                     (sts)
  );

endmodule

// ===== src/fbpa_ctrl.sv =====
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fbpa_sts_t sts,
  output fbpa_ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_ALLOC: begin
            if (!sts.stack_empty) state_nxt = S_POP_RD;
            else if (sts.grow_allowed && sts.grow_fits) state_nxt = S_GROW;
            else state_nxt = S_DONE;
          end
          CMD_FREE: state_nxt = S_FREE_MUL;
          CMD_GROW: begin
            if (sts.grow_allowed && sts.grow_fits && !sts.grow_zero) state_nxt = S_GROW;
            else state_nxt = S_DONE;
          end
          default: state_nxt = S_CLEAR;
        endcase
      end
      S_GROW: begin
        if (sts.grow_last) state_nxt = (sts.cmd == CMD_ALLOC) ? S_POP_RD : S_DONE;
      end
      S_CLEAR: begin
        if (sts.sweep_last) state_nxt = S_DONE;
      end
      S_POP_RD:   state_nxt = S_POP_MUL;
      S_POP_MUL:  state_nxt = S_POP_FIN;
      S_POP_FIN:  state_nxt = S_DONE;
      S_FREE_MUL: state_nxt = S_FREE_CHK;
      S_FREE_CHK: state_nxt = sts.free_bad ? S_DONE : S_DIV;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_BIT_RD;
      end
      S_BIT_RD:   state_nxt = sts.rem_nonzero ? S_DONE : S_BIT_CHK;
      S_BIT_CHK:  state_nxt = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.res_code = RS_OK;
    in_ready     = 1'b0;
    case (state_r)
      S_INIT: ctl.sweep_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.take = in_valid;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_ALLOC: begin
            if (sts.stack_empty) begin
              if (sts.grow_allowed && sts.grow_fits) begin
                ctl.grow_start = 1'b1;
              end else begin
                ctl.fail_count = 1'b1;
                ctl.res_set    = 1'b1;
                ctl.res_code   = RS_EXHAUSTED;
              end
            end
          end
          CMD_GROW: begin
            if (sts.grow_allowed && sts.grow_fits) begin
              if (sts.grow_zero) ctl.res_set = 1'b1;
              else ctl.grow_start = 1'b1;
            end else begin
              ctl.res_set  = 1'b1;
              ctl.res_code = RS_GROW_REFUSED;
            end
          end
          default: ;
        endcase
      end
      S_GROW: begin
        ctl.grow_step = 1'b1;
        if (sts.grow_last && sts.cmd != CMD_ALLOC) ctl.res_set = 1'b1;
      end
      S_CLEAR: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          ctl.clear_done = 1'b1;
          ctl.res_set    = 1'b1;
        end
      end
      S_POP_RD:  ctl.pop_read = 1'b1;
      S_POP_MUL: ctl.pop_mul = 1'b1;
      S_POP_FIN: begin
        ctl.pop_commit = 1'b1;
        ctl.res_set    = 1'b1;
      end
      S_FREE_MUL: ctl.free_prep = 1'b1;
      S_FREE_CHK: begin
        if (sts.free_bad) begin
          ctl.res_set  = 1'b1;
          ctl.res_code = RS_BAD_ADDRESS;
        end else begin
          ctl.div_start = 1'b1;
        end
      end
      S_DIV: ctl.div_step = 1'b1;
      S_BIT_RD: begin
        if (sts.rem_nonzero) begin
          ctl.res_set  = 1'b1;
          ctl.res_code = RS_BAD_ADDRESS;
        end else begin
          ctl.bit_read = 1'b1;
        end
      end
      S_BIT_CHK: begin
        ctl.res_set = 1'b1;
        if (sts.bit_set) ctl.free_commit = 1'b1;
        else ctl.res_code = RS_NOT_ALLOC;
      end
      S_DONE: ctl.result_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== src/fbpa_dp.sv =====
module fbpa_dp import fbpa_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  cmd_t                      in_cmd,
  input  logic [AW-1:0]             in_address,
  input  logic [CNT_W-1:0]          in_grow_count,
  input  logic                      in_force_grow,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      out_ok,
  output res_status_t               out_status,
  output logic [AW-1:0]             out_block_address,
  output logic [IDX_OUT_W-1:0]      out_block_index,
  output logic [CNT_W-1:0]          out_free_blocks,
  output logic [CNT_W-1:0]          out_active_blocks,
  output logic [CTR_W-1:0]          out_total_allocations,
  output logic [CTR_W-1:0]          out_total_releases,
  output logic [CTR_W-1:0]          out_allocation_failures,
  input  fbpa_ctl_t                 ctl,
  output fbpa_sts_t                 sts
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int FW   = ((CW > CNT_W) ? CW : CNT_W) + 1;
  localparam int PW   = IW + SZW;
  localparam int RGW  = CW + SZW;
  localparam int CMPW = (RGW > AW) ? RGW : AW;
  localparam int DCW  = $clog2(AW);
  localparam logic [CW-1:0] RST_BLKS =
    (CAPACITY < 256) ? CW'(CAPACITY) : CW'(256);

  // configuration
  logic [AW-1:0]         base_r;
  logic [SIZE_REQ_W-1:0] size_req_r;
  logic [TIER_W-1:0]     tier_r;
  logic [CNT_W-1:0]      init_blks_r;
  logic                  allow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= RST_POOL_BASE;
      size_req_r  <= RST_SIZE_REQ;
      tier_r      <= RST_TIER;
      init_blks_r <= RST_INIT_BLKS;
      allow_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POOL_BASE:  base_r      <= cfg_data[AW-1:0];
        CFG_SIZE_REQ:   size_req_r  <= cfg_data[SIZE_REQ_W-1:0];
        CFG_TIER:       tier_r      <= cfg_data[TIER_W-1:0];
        CFG_INIT_BLKS:  init_blks_r <= cfg_data[CNT_W-1:0];
        CFG_ALLOW_GROW: allow_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SZW-1:0] size;
  assign size = eff_size(size_req_r, tier_r);

  // item
  cmd_t             cmd_r;
  logic [AW-1:0]    addr_r;
  logic [CNT_W-1:0] gcnt_r;
  logic             force_r;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_address;
      gcnt_r  <= in_grow_count;
      force_r <= in_force_grow;
    end
  end

  // memories
  logic [IW-1:0] stk_mem [CAPACITY];
  logic          bit_mem [CAPACITY];
  logic          stk_we, bit_we, bit_wd, bit_re;
  logic [IW-1:0] stk_wa, stk_wd, stk_ra, bit_wa, bit_ra;
  logic [IW-1:0] stk_rd_r;
  logic          bit_rd_r;

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (ctl.pop_read) stk_rd_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (bit_we) bit_mem[bit_wa] <= bit_wd;
    if (bit_re) bit_rd_r <= bit_mem[bit_ra];
  end

  // state
  logic [CW-1:0]    depth_r, pool_r;
  logic [CTR_W-1:0] alloc_cnt_r, rel_cnt_r, fail_cnt_r;
  logic [IW-1:0]    sw_r;
  logic [CNT_W-1:0] left_r;
  logic [CNT_W-1:0] auto_step, gsel;
  logic [FW-1:0]    gsum;

  logic [IW-1:0]    idx_r;
  logic [PW-1:0]    prod_r;
  logic [AW-1:0]    off_r;
  logic [RGW-1:0]   range_r;
  logic [AW-1:0]    dq_r;
  logic [SZW-1:0]   rem_r;
  logic [DCW-1:0]   dcnt_r;
  logic [SZW:0]     rem_sh;
  logic             rem_ge;
  logic [IW-1:0]    qidx;

  assign auto_step = ((init_blks_r >> 2) < CNT_W'(AUTO_MIN)) ? CNT_W'(AUTO_MIN)
                                                              : (init_blks_r >> 2);
  assign gsel   = (cmd_r == CMD_GROW) ? gcnt_r : auto_step;
  assign gsum   = FW'(pool_r) + FW'(gsel);
  assign rem_sh = {rem_r, dq_r[AW-1]};
  assign rem_ge = rem_sh >= {1'b0, size};
  assign qidx   = dq_r[IW-1:0];

  always_comb begin
    stk_we = 1'b0;
    stk_wa = sw_r;
    stk_wd = sw_r;
    if (ctl.sweep_step) begin
      stk_we = 1'b1;
    end else if (ctl.grow_step) begin
      stk_we = depth_r < CW'(CAPACITY);
      stk_wa = IW'(depth_r);
      stk_wd = IW'(pool_r);
    end else if (ctl.free_commit) begin
      stk_we = depth_r < CW'(CAPACITY);
      stk_wa = IW'(depth_r);
      stk_wd = qidx;
    end
    stk_ra = IW'(depth_r - CW'(1));
  end

  always_comb begin
    bit_we = 1'b0;
    bit_wa = sw_r;
    bit_wd = 1'b0;
    if (ctl.sweep_step) begin
      bit_we = 1'b1;
    end else if (ctl.pop_mul) begin
      bit_we = 1'b1;
      bit_wa = stk_rd_r;
      bit_wd = 1'b1;
    end else if (ctl.free_commit) begin
      bit_we = 1'b1;
      bit_wa = qidx;
    end
    bit_re = ctl.bit_read;
    bit_ra = qidx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= RST_BLKS;
      pool_r      <= RST_BLKS;
      alloc_cnt_r <= '0;
      rel_cnt_r   <= '0;
      fail_cnt_r  <= '0;
      sw_r        <= '0;
      left_r      <= '0;
      dcnt_r      <= '0;
    end else begin
      if (ctl.sweep_step) sw_r <= (sw_r == IW'(CAPACITY - 1)) ? '0 : sw_r + IW'(1);
      if (ctl.clear_done) depth_r <= pool_r;
      if (ctl.grow_start) left_r <= gsel;
      if (ctl.grow_step) begin
        left_r <= left_r - CNT_W'(1);
        pool_r <= pool_r + CW'(1);
        if (depth_r < CW'(CAPACITY)) depth_r <= depth_r + CW'(1);
      end
      if (ctl.pop_read) depth_r <= depth_r - CW'(1);
      if (ctl.pop_commit) alloc_cnt_r <= alloc_cnt_r + CTR_W'(1);
      if (ctl.fail_count) fail_cnt_r <= fail_cnt_r + CTR_W'(1);
      if (ctl.free_commit) begin
        rel_cnt_r <= rel_cnt_r + CTR_W'(1);
        if (depth_r < CW'(CAPACITY)) depth_r <= depth_r + CW'(1);
      end
      if (ctl.div_start) dcnt_r <= '0;
      else if (ctl.div_step) dcnt_r <= dcnt_r + DCW'(1);
    end
  end

  // address math and restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.pop_mul) begin
      idx_r  <= stk_rd_r;
      prod_r <= PW'(stk_rd_r) * PW'(size);
    end
    if (ctl.free_prep) begin
      off_r   <= addr_r - base_r;
      range_r <= RGW'(pool_r) * RGW'(size);
    end
    if (ctl.div_start) begin
      dq_r  <= off_r;
      rem_r <= '0;
    end else if (ctl.div_step) begin
      dq_r  <= {dq_r[AW-2:0], rem_ge};
      rem_r <= rem_ge ? SZW'(rem_sh - {1'b0, size}) : SZW'(rem_sh);
    end
  end

  // result
  logic             res_ok_r;
  res_status_t      res_status_r;
  logic [AW-1:0]    res_addr_r;
  logic [IW-1:0]    res_idx_r;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      res_addr_r <= '0;
      res_idx_r  <= '0;
    end
    if (ctl.pop_commit) begin
      res_addr_r <= base_r + AW'(prod_r);
      res_idx_r  <= idx_r;
    end
    if (ctl.free_commit) res_idx_r <= qidx;
    if (ctl.res_set) begin
      res_ok_r     <= ctl.res_code == RS_OK;
      res_status_r <= ctl.res_code;
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      out_ok                  <= res_ok_r;
      out_status              <= res_status_r;
      out_block_address       <= res_addr_r;
      out_block_index         <= IDX_OUT_W'(res_idx_r);
      out_free_blocks         <= CNT_W'(depth_r);
      out_active_blocks       <= CNT_W'(pool_r);
      out_total_allocations   <= alloc_cnt_r;
      out_total_releases      <= rel_cnt_r;
      out_allocation_failures <= fail_cnt_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts              = '0;
    sts.cmd          = cmd_r;
    sts.stack_empty  = depth_r == '0;
    sts.grow_allowed = allow_r | (force_r & (cmd_r == CMD_GROW));
    sts.grow_fits    = gsum <= FW'(CAPACITY);
    sts.grow_zero    = gsel == '0;
    sts.sweep_last   = sw_r == IW'(CAPACITY - 1);
    sts.grow_last    = left_r == CNT_W'(1);
    sts.div_last     = dcnt_r == DCW'(AW - 1);
    sts.free_bad     = (addr_r == '0) || (CMPW'(off_r) >= CMPW'(range_r));
    sts.rem_nonzero  = rem_r != '0;
    sts.bit_set      = bit_rd_r;
    sts.out_busy     = out_valid_r & !out_ready;
  end

endmodule

// ===== verif/tb_fixed_block_pool_allocator.sv =====
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic        ok;
    res_status_t status;
    logic [31:0] block_address;
    logic [9:0]  block_index;
    logic [10:0] free_blocks;
    logic [10:0] active_blocks;
    logic [31:0] total_allocations;
    logic [31:0] total_releases;
    logic [31:0] allocation_failures;
  } pool_result_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] address;
    logic [10:0] grow_count;
    logic        force_grow;
    logic        has_fixed;
    res_status_t fixed_status;
  } pool_request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fbpa_in_if in_ch ();
  fbpa_out_if out_ch ();

  fixed_block_pool_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // shadow of the pool
  logic [31:0] sh_base;
  logic [15:0] sh_size_req;
  logic [1:0]  sh_tier;
  logic [10:0] sh_init;
  logic        sh_grow;
  logic [9:0]  sh_stack [CAP];
  int          sh_depth;
  logic        sh_alloc [CAP];
  int          sh_pool;
  logic [31:0] sh_allocs, sh_releases, sh_failures;

  pool_result_t pending_results[$];
  res_status_t  pending_status_fixed[$];
  logic         pending_has_fixed[$];
  logic [31:0]  live_addrs[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  logic quiet = 1'b0;
  logic hold_ready_low = 1'b0;

  function automatic logic [31:0] block_bytes();
    logic [31:0] s, a;
    s = (sh_size_req < 16'd8) ? 32'd8 : {16'd0, sh_size_req};
    a = (sh_tier == 2'd0) ? 32'd32 : (sh_tier == 2'd1) ? 32'd16 :
        (sh_tier == 2'd2) ? 32'd8 : 32'd4;
    return (s + a - 1) & ~(a - 1);
  endfunction

  function automatic void push_free(int idx);
    if (sh_depth < CAP) begin
      sh_stack[sh_depth] = idx[9:0];
      sh_depth++;
    end
  endfunction

  function automatic void refill_pool(int n);
    for (int i = 0; i < CAP; i++) sh_alloc[i] = 1'b0;
    sh_depth = 0;
    for (int i = 0; i < n && i < CAP; i++) push_free(i);
  endfunction

  function automatic bit extend_pool(int count, bit forced);
    if (!sh_grow && !forced) return 0;
    if (count == 0) return 1;
    if (sh_pool + count > CAP) return 0;
    for (int i = 0; i < count; i++) push_free(sh_pool + i);
    sh_pool += count;
    return 1;
  endfunction

  function automatic pool_result_t serve_request(pool_request_t rq);
    pool_result_t r;
    logic [31:0] size, offset;
    longint range;
    int b, stepn;
    bit avail;
    r = '0;
    r.status = RS_OK;
    size = block_bytes();
    case (rq.cmd)
      CMD_ALLOC: begin
        avail = sh_depth != 0;
        if (!avail && sh_grow) begin
          stepn = sh_init / 4;
          if (stepn < 32) stepn = 32;
          avail = extend_pool(stepn, 0) && sh_depth != 0;
        end
        if (!avail) begin
          r.status = RS_EXHAUSTED;
          sh_failures++;
        end else begin
          sh_depth--;
          b = sh_stack[sh_depth];
          sh_alloc[b] = 1'b1;
          r.block_address = sh_base + b * size;
          r.block_index = b[9:0];
          sh_allocs++;
          r.ok = 1'b1;
        end
      end
      CMD_FREE: begin
        offset = rq.address - sh_base;
        range = longint'(sh_pool) * size;
        if (rq.address == 0 || offset >= range || (offset % size) != 0) begin
          r.status = RS_BAD_ADDRESS;
        end else begin
          b = offset / size;
          if (b >= CAP || !sh_alloc[b]) begin
            r.status = RS_NOT_ALLOC;
          end else begin
            sh_alloc[b] = 1'b0;
            push_free(b);
            sh_releases++;
            r.block_index = b[9:0];
            r.ok = 1'b1;
          end
        end
      end
      CMD_GROW: begin
        if (extend_pool(rq.grow_count, rq.force_grow)) r.ok = 1'b1;
        else r.status = RS_GROW_REFUSED;
      end
      default: begin
        refill_pool(sh_pool);
        r.ok = 1'b1;
      end
    endcase
    r.free_blocks = sh_depth[10:0];
    r.active_blocks = sh_pool[10:0];
    r.total_allocations = sh_allocs;
    r.total_releases = sh_releases;
    r.allocation_failures = sh_failures;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, what, got, want);
  endtask

  // result side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        pool_result_t w;
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          errors++;
          $display("unexpected result with status %0d", out_ch.status);
        end else begin
          w = pending_results.pop_front();
          if (pending_has_fixed.pop_front() && out_ch.status !== pending_status_fixed[0])
            report_mismatch("table status", out_ch.status, pending_status_fixed[0]);
          void'(pending_status_fixed.pop_front());
          if (out_ch.ok !== w.ok) report_mismatch("ok", out_ch.ok, w.ok);
          if (out_ch.status !== w.status) report_mismatch("status", out_ch.status, w.status);
          if (out_ch.block_address !== w.block_address)
            report_mismatch("block_address", out_ch.block_address, w.block_address);
          if (out_ch.block_index !== w.block_index)
            report_mismatch("block_index", out_ch.block_index, w.block_index);
          if (out_ch.free_blocks !== w.free_blocks)
            report_mismatch("free_blocks", out_ch.free_blocks, w.free_blocks);
          if (out_ch.active_blocks !== w.active_blocks)
            report_mismatch("active_blocks", out_ch.active_blocks, w.active_blocks);
          if (out_ch.total_allocations !== w.total_allocations)
            report_mismatch("total_allocations", out_ch.total_allocations,
                            w.total_allocations);
          if (out_ch.total_releases !== w.total_releases)
            report_mismatch("total_releases", out_ch.total_releases, w.total_releases);
          if (out_ch.allocation_failures !== w.allocation_failures)
            report_mismatch("allocation_failures", out_ch.allocation_failures,
                            w.allocation_failures);
          if (out_ch.ok === 1'b1 && w.ok && w.block_address != 0)
            live_addrs.push_back(w.block_address);
        end
      end
      if (quiet || (!hold_ready_low && $urandom_range(0, 3) != 0)) out_ch.ready <= 1'b1;
      else out_ch.ready <= 1'b0;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_block_pool_allocator regression: fail");
      $finish;
    end
  end

  // stall bursts on the result side
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 30) == 0) begin
        force_ready_low($urandom_range(1, 17));
      end
    end
  end

  task automatic force_ready_low(int n);
    hold_ready_low = 1'b1;
    repeat (n) @(posedge clk);
    hold_ready_low = 1'b0;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POOL_BASE:  sh_base = val;
      CFG_SIZE_REQ:   sh_size_req = val[15:0];
      CFG_TIER:       sh_tier = val[1:0];
      CFG_INIT_BLKS:  sh_init = val[10:0];
      default:        sh_grow = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic send(pool_request_t rq);
    if (!quiet && $urandom_range(0, 12) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= rq.cmd;
    in_ch.address <= rq.address;
    in_ch.grow_count <= rq.grow_count;
    in_ch.force_grow <= rq.force_grow;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(serve_request(rq));
    pending_has_fixed.push_back(rq.has_fixed);
    pending_status_fixed.push_back(rq.fixed_status);
  endtask

  function automatic pool_request_t mk(cmd_t c, logic [31:0] a, logic [10:0] g, logic f,
                                       logic hf, res_status_t st);
    pool_request_t rq;
    rq.cmd = c; rq.address = a; rq.grow_count = g; rq.force_grow = f;
    rq.has_fixed = hf; rq.fixed_status = st;
    return rq;
  endfunction

  function automatic logic [31:0] pick_free_addr();
    int k, sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && live_addrs.size() != 0) begin
      k = $urandom_range(0, live_addrs.size() - 1);
      pick_free_addr = live_addrs[k];
      live_addrs.delete(k);
    end else if (sel < 8) begin
      pick_free_addr = sh_base + $urandom_range(0, sh_pool + 3) * block_bytes();
    end else begin
      pick_free_addr = $urandom;
    end
  endfunction

  function automatic pool_request_t rand_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return mk(CMD_ALLOC, $urandom, 11'($urandom), 1'($urandom), 0, RS_OK);
    if (r < 88)
      return mk(CMD_FREE, pick_free_addr(), 11'($urandom), 1'($urandom), 0, RS_OK);
    if (r < 98)
      return mk(CMD_GROW, $urandom, ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                : 11'($urandom_range(0, 40)), 1'($urandom), 0, RS_OK);
    return mk(CMD_CLEAR, $urandom, 11'($urandom), 1'($urandom), 0, RS_OK);
  endfunction

  pool_request_t directed [$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ALLOC;
    in_ch.address = '0;
    in_ch.grow_count = '0;
    in_ch.force_grow = 1'b0;
    sh_base = 32'd65536; sh_size_req = 16'd64; sh_tier = 2'd0; sh_init = 11'd256;
    sh_grow = 1'b0; sh_pool = 256; sh_allocs = 0; sh_releases = 0; sh_failures = 0;
    refill_pool(256);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk(CMD_FREE, 32'd0, 0, 0, 1, RS_BAD_ADDRESS));
    directed.push_back(mk(CMD_FREE, 32'd65536, 0, 0, 1, RS_NOT_ALLOC));
    directed.push_back(mk(CMD_FREE, 32'hFFFF_FFFF, 0, 0, 1, RS_BAD_ADDRESS));
    directed.push_back(mk(CMD_FREE, 32'd65537, 0, 0, 1, RS_BAD_ADDRESS));
    directed.push_back(mk(CMD_ALLOC, 0, 0, 0, 1, RS_OK));
    directed.push_back(mk(CMD_ALLOC, 0, 0, 0, 1, RS_OK));
    directed.push_back(mk(CMD_FREE, 32'd65536 + 255 * 64, 0, 0, 1, RS_OK));
    directed.push_back(mk(CMD_FREE, 32'd65536 + 255 * 64, 0, 0, 1, RS_NOT_ALLOC));
    directed.push_back(mk(CMD_FREE, 32'd65536 + 256 * 64, 0, 0, 1, RS_BAD_ADDRESS));
    directed.push_back(mk(CMD_GROW, 0, 11'd10, 1'b0, 1, RS_GROW_REFUSED));
    directed.push_back(mk(CMD_GROW, 0, 11'd0, 1'b1, 1, RS_OK));
    directed.push_back(mk(CMD_GROW, 0, 11'd2047, 1'b1, 1, RS_GROW_REFUSED));
    directed.push_back(mk(CMD_GROW, 0, 11'd8, 1'b1, 1, RS_OK));
    directed.push_back(mk(CMD_GROW, 0, 11'd761, 1'b1, 1, RS_GROW_REFUSED));
    directed.push_back(mk(CMD_CLEAR, 32'hFFFF_FFFF, 11'h7FF, 1'b1, 1, RS_OK));
    directed.push_back(mk(CMD_FREE, 32'd65536 + 64, 0, 0, 1, RS_NOT_ALLOC));
    foreach (directed[i]) send(directed[i]);
    drain();

    // exhaust a small pool
    write_reg(CFG_SIZE_REQ, 32'd1);
    write_reg(CFG_TIER, 32'd3);
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFF0);
    for (int i = 0; i < 265; i++) send(mk(CMD_ALLOC, 0, 0, 0, 0, RS_OK));
    send(mk(CMD_FREE, 32'hFFFF_FFF8, 0, 0, 1, RS_OK));
    send(mk(CMD_CLEAR, 0, 0, 0, 1, RS_OK));
    drain();
    live_addrs.delete();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_POOL_BASE, (ph == 4) ? 32'd1 : $urandom);
      write_reg(CFG_SIZE_REQ, (ph == 1) ? 32'd65535 : $urandom_range(1, 200));
      write_reg(CFG_TIER, ph % 4);
      write_reg(CFG_INIT_BLKS, (ph == 2) ? 32'd1024 : (ph == 3) ? 32'd1 : $urandom_range(1, 1024));
      write_reg(CFG_ALLOW_GROW, ph % 2);
      live_addrs.delete();
      if (ph == 4) quiet = 1'b1;
      for (int i = 0; i < 160; i++) send(rand_request());
      drain();
      send(mk(CMD_CLEAR, 0, 0, 0, 1, RS_OK));
      drain();
      live_addrs.delete();
    end

    $display("covered all commands, every status, auto growth, wraparound bases and");
    $display("all tiers over %0d results", results_seen);
    if (errors == 0) begin
      $display("fixed_block_pool_allocator regression: pass");
    end else begin
      $display("fixed_block_pool_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fbpa_pkg.sv
src/fbpa_if.sv
src/fbpa_ctrl.sv
src/fbpa_dp.sv
src/fixed_block_pool_allocator.sv
verif/tb_fixed_block_pool_allocator.sv
